// ----- rtl/lufpt_pkg.sv -----
// Shared types, codes and constants of the least-used-first priority table.
package lufpt_pkg;

   localparam int SLOTS   = 32;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 16;
   localparam int SLICE_W = 16;
   localparam int QC_W    = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [QC_W-1:0]    QC_RESET     = 8'd16;
   localparam logic [SLOT_W-1:0]  LAST_SLOT    = SLOT_W'(SLOTS - 1);

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_INHERIT = 2'd1;
   localparam logic [1:0] MODE_STOP    = 2'd2;
   localparam logic [1:0] MODE_EXPIRE  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd1;
   localparam logic [1:0] STATUS_BAD_PRIO = 2'd2;

   localparam logic [1:0] PRIO_NONE  = 2'd0;
   localparam logic [1:0] PRIO_LEAST = 2'd1;
   localparam logic [1:0] PRIO_OTHER = 2'd2;

   localparam logic [1:0] RD_SLOT   = 2'd0;
   localparam logic [1:0] RD_PARENT = 2'd1;
   localparam logic [1:0] RD_SCAN   = 2'd2;

   typedef struct packed {
      logic       latch;
      logic       check;
      logic       clear_use;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       update;
      logic       scan_init;
      logic       min_issue;
      logic       min_step;
      logic       idx_inc;
      logic       idx_clr;
      logic       out_single;
      logic       out_slot;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic is_stop;
      logic cur_used;
      logic idx_end;
      logic last_used;
      logic out_free;
   } stat_type;

   function automatic logic slot_ok(logic [SLOT_W-1:0] s);
      return (32'(s) < SLOTS);
   endfunction

endpackage

// ----- rtl/lufpt_ctrl.sv -----
// Sequencer: check, table update, minimum scan and result scan.
module lufpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lufpt_pkg::stat_type stat,
   output lufpt_pkg::cmd_type  cmd
);
   import lufpt_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CHECK   = 3'd1;
   localparam logic [2:0] ST_UPDATE  = 3'd2;
   localparam logic [2:0] ST_MIN     = 3'd3;
   localparam logic [2:0] ST_MIN_END = 3'd4;
   localparam logic [2:0] ST_EMIT_RD = 3'd5;
   localparam logic [2:0] ST_EMIT_WR = 3'd6;
   localparam logic [2:0] ST_SINGLE  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (stat.err) begin
               state_in = ST_SINGLE;
            end else if (stat.is_stop) begin
               cmd.clear_use = 1'b1;
               state_in      = ST_SINGLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update    = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = ST_MIN;
         end
         ST_MIN: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_SCAN;
            cmd.min_issue = 1'b1;
            cmd.min_step  = 1'b1;
            cmd.idx_inc   = 1'b1;
            if (stat.idx_end) begin
               state_in = ST_MIN_END;
            end
         end
         ST_MIN_END: begin
            cmd.min_step = 1'b1;
            cmd.idx_clr  = 1'b1;
            state_in     = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            if (stat.cur_used) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SCAN;
               state_in   = ST_EMIT_WR;
            end else if (stat.idx_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_EMIT_WR: begin
            if (stat.out_free) begin
               cmd.out_slot = 1'b1;
               if (stat.last_used) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         ST_SINGLE: begin
            if (stat.out_free) begin
               cmd.out_single = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lufpt_dp.sv -----
// Datapath: slot table, count and slice memories, minimum tracker, result register.
module lufpt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  lufpt_pkg::cmd_type            cmd,
   output lufpt_pkg::stat_type           stat,
   input  logic [1:0]                    req_mode,
   input  logic [lufpt_pkg::SLOT_W-1:0]  req_slot,
   input  logic [lufpt_pkg::SLOT_W-1:0]  req_parent_slot,
   input  logic [7:0]                    req_prio_cap,
   input  logic [lufpt_pkg::SLICE_W-1:0] req_quantum,
   input  logic                          csr_wr_en,
   input  logic [lufpt_pkg::QC_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [lufpt_pkg::SLOT_W-1:0]  rsp_out_slot,
   output logic [1:0]                    rsp_priority_res,
   output logic [lufpt_pkg::SLICE_W-1:0] rsp_out_quantum,
   output logic                          rsp_last
);
   import lufpt_pkg::*;

   logic [1:0]         mode_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  parent_ff;
   logic [7:0]         maxp_ff;
   logic [SLICE_W-1:0] quantum_ff;
   logic [QC_W-1:0]    qc_ff;
   logic [SLOTS-1:0]   in_use_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic               pipe_vld_ff;
   logic [COUNT_W-1:0] min_ff;
   logic [1:0]         single_status_ff;

   logic [COUNT_W-1:0] cnt_mem [SLOTS];
   logic [SLICE_W-1:0] slc_mem [SLOTS];
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [SLICE_W-1:0] slc_rd_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [1:0]         rsp_prio_ff;
   logic [SLICE_W-1:0] rsp_quantum_ff;
   logic               rsp_last_ff;

   logic               is_alloc;
   logic [1:0]         chk_status;
   logic [SLOT_W-1:0]  rd_addr;
   logic [SLOTS-1:0]   upper_use;
   logic               out_free;
   logic [COUNT_W-1:0] cnt_inc;

   function automatic logic req_mode_sel(logic [1:0] m);
      return m inside {MODE_START, MODE_INHERIT};
   endfunction

   assign is_alloc = (req_mode_sel(mode_ff));

   always_comb begin
      chk_status = STATUS_OK;
      if (!slot_ok(slot_ff)) begin
         chk_status = STATUS_BAD_SLOT;
      end else if (is_alloc) begin
         if (in_use_ff[slot_ff]) begin
            chk_status = STATUS_BAD_SLOT;
         end else if (maxp_ff >= qc_ff) begin
            chk_status = STATUS_BAD_PRIO;
         end else if ((mode_ff == MODE_INHERIT) &&
                      (!slot_ok(parent_ff) || !in_use_ff[parent_ff])) begin
            chk_status = STATUS_BAD_SLOT;
         end
      end else if (!in_use_ff[slot_ff]) begin
         chk_status = STATUS_BAD_SLOT;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_SLOT:   rd_addr = slot_ff;
         RD_PARENT: rd_addr = (mode_ff == MODE_INHERIT) ? parent_ff : slot_ff;
         RD_SCAN:   rd_addr = idx_ff;
         default:   rd_addr = slot_ff;
      endcase
   end

   assign upper_use = in_use_ff >> idx_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_inc   = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;

   assign stat.err       = (chk_status != STATUS_OK);
   assign stat.is_stop   = (mode_ff == MODE_STOP);
   assign stat.cur_used  = in_use_ff[idx_ff];
   assign stat.idx_end   = (idx_ff == LAST_SLOT);
   assign stat.last_used = (upper_use[SLOTS-1:1] == '0);
   assign stat.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff    <= req_mode;
         slot_ff    <= req_slot;
         parent_ff  <= req_parent_slot;
         maxp_ff    <= req_prio_cap;
         quantum_ff <= req_quantum;
      end
      if (cmd.check) begin
         single_status_ff <= chk_status;
      end
      if (cmd.rd_en) begin
         cnt_rd_ff <= cnt_mem[rd_addr];
         slc_rd_ff <= slc_mem[rd_addr];
      end
      if (cmd.update) begin
         if (is_alloc) begin
            cnt_mem[slot_ff] <= '0;
            slc_mem[slot_ff] <= (mode_ff == MODE_INHERIT) ? slc_rd_ff : quantum_ff;
         end else begin
            cnt_mem[slot_ff] <= cnt_inc;
         end
      end
      if (cmd.scan_init) begin
         min_ff <= COUNT_MAX;
      end else if (cmd.min_step && pipe_vld_ff && (cnt_rd_ff < min_ff)) begin
         min_ff <= cnt_rd_ff;
      end
      if (cmd.out_single) begin
         rsp_status_ff  <= single_status_ff;
         rsp_slot_ff    <= '0;
         rsp_prio_ff    <= PRIO_NONE;
         rsp_quantum_ff <= '0;
         rsp_last_ff    <= 1'b1;
      end else if (cmd.out_slot) begin
         rsp_status_ff  <= STATUS_OK;
         rsp_slot_ff    <= idx_ff;
         rsp_prio_ff    <= (cnt_rd_ff == min_ff) ? PRIO_LEAST : PRIO_OTHER;
         rsp_quantum_ff <= slc_rd_ff;
         rsp_last_ff    <= stat.last_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qc_ff        <= QC_RESET;
         in_use_ff    <= '0;
         idx_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            qc_ff <= csr_wr_data;
         end
         if (cmd.clear_use) begin
            in_use_ff[slot_ff] <= 1'b0;
         end else if (cmd.update && is_alloc) begin
            in_use_ff[slot_ff] <= 1'b1;
         end
         if (cmd.scan_init || cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         pipe_vld_ff <= cmd.min_issue && in_use_ff[idx_ff];
         if (cmd.out_single || cmd.out_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_slot     = rsp_slot_ff;
   assign rsp_priority_res = rsp_prio_ff;
   assign rsp_out_quantum  = rsp_quantum_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ----- rtl/least_used_first_priority_table_top.sv -----
// Top level of the least-used-first priority table.
// Errors and stop: after the accept and check steps a single item is loaded into the result register.
// Start, inherit, expire: accept, check and update, then a minimum scan over all slots, then a
// result scan that skips free slots and reads and emits each in-use slot up to the highest one.
// One item at a time; a loaded result that waits on rsp_stall holds up the sequence.
// Reset (synchronous): all slots free, queue count 16, count and slice memories not cleared.
module least_used_first_priority_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [lufpt_pkg::SLOT_W-1:0]  req_slot,
   input  logic [lufpt_pkg::SLOT_W-1:0]  req_parent_slot,
   input  logic [7:0]                    req_prio_cap,
   input  logic [lufpt_pkg::SLICE_W-1:0] req_quantum,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [lufpt_pkg::SLOT_W-1:0]  rsp_out_slot,
   output logic [1:0]                    rsp_priority_res,
   output logic [lufpt_pkg::SLICE_W-1:0] rsp_out_quantum,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [lufpt_pkg::QC_W-1:0]    csr_wr_data
);
   import lufpt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lufpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lufpt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_parent_slot  (req_parent_slot),
      .req_prio_cap     (req_prio_cap),
      .req_quantum      (req_quantum),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_priority_res (rsp_priority_res),
      .rsp_out_quantum  (rsp_out_quantum),
      .rsp_last         (rsp_last)
   );

endmodule

// ----- rtl/lufpt_checker.sv -----
// Port-level checks of the priority table, bound to the top level.
module lufpt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [lufpt_pkg::SLOT_W-1:0]  rsp_out_slot,
   input logic [1:0]                    rsp_priority_res,
   input logic                          rsp_last
);
   import lufpt_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in work");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
      (rsp_last && (rsp_priority_res == PRIO_NONE) && (rsp_out_slot == '0)))
      else $error("error item is not a lone final item");

   a_prio_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OK) && (rsp_priority_res == PRIO_NONE)) |->
      (rsp_last && (rsp_out_slot == '0)))
      else $error("stop item malformed");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_priority_res != 2'd3))
      else $error("priority code out of range");

endmodule

bind least_used_first_priority_table_top lufpt_checker u_lufpt_checker (.*);
